FILE: hw/rtl/chlcd_pkg.sv
`default_nettype none
package chlcd_pkg;

    localparam int NUM_COLUMNS     = 16;
    localparam int NUM_ROWS        = 2;
    localparam int CFG_INDEX_W     = 4;
    localparam int CFG_DATA_W      = 16;
    localparam int INIT_CMD_COUNT  = 5;

    localparam logic [15:0] INIT_WAIT_LONG  = 16'd5000;
    localparam logic [15:0] INIT_WAIT_SHORT = 16'd1000;

    localparam logic [7:0] CURSOR_BASE = 8'h80;
    localparam logic [7:0] ROW_STRIDE  = 8'h40;

    localparam logic [3:0] INIT_NIBBLE_8BIT = 4'h3;
    localparam logic [3:0] INIT_NIBBLE_4BIT = 4'h2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_POWER_ON_WAIT = 4'd0,
        REG_COMMAND_WAIT  = 4'd1,
        REG_DATA_WAIT     = 4'd2,
        REG_ENABLE_PULSE  = 4'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ACT_TICK          = 3'd0,
        ACT_INIT          = 3'd1,
        ACT_COMMAND       = 3'd2,
        ACT_WRITE_CHAR    = 3'd3,
        ACT_BACKLIGHT_ON  = 3'd4,
        ACT_BACKLIGHT_OFF = 3'd5,
        ACT_MOVE_CURSOR   = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_OWNER = 2'd1,
        STAT_BUSY      = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE          = 5'd0,
        ST_INIT_POWER    = 5'd1,
        ST_INIT_PULSE1   = 5'd2,
        ST_INIT_WAIT1    = 5'd3,
        ST_INIT_PULSE2   = 5'd4,
        ST_INIT_WAIT2    = 5'd5,
        ST_INIT_PULSE3   = 5'd6,
        ST_INIT_WAIT3    = 5'd7,
        ST_INIT_PULSE4   = 5'd8,
        ST_INIT_WAIT4    = 5'd9,
        ST_BYTE_SETUP_HI = 5'd10,
        ST_BYTE_PULSE_HI = 5'd11,
        ST_BYTE_SETUP_LO = 5'd12,
        ST_BYTE_PULSE_LO = 5'd13,
        ST_BYTE_WAIT     = 5'd14
    } seq_step_t;

    typedef struct packed {
        logic [15:0] power_on_wait_ticks;
        logic [15:0] command_wait_ticks;
        logic [15:0] data_wait_ticks;
        logic [7:0]  enable_pulse_ticks;
    } lcd_cfg_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] byte_value;
        logic [7:0] column;
        logic [7:0] row;
        logic       caller_is_owner;
    } lcd_item_t;

    typedef struct packed {
        logic       pin_rs;
        logic       pin_enable;
        logic [3:0] pin_nibble;
        logic       pin_backlight;
        logic       busy_res;
        logic [1:0] status;
    } lcd_result_t;

    function automatic logic [7:0] init_cmd(input logic [2:0] idx);
        logic [7:0] cmd;
        case (idx)
            3'd0:    cmd = 8'b0010_1000;  // 4-bit bus, two lines
            3'd1:    cmd = 8'b0000_1000;  // display off
            3'd2:    cmd = 8'h01;         // clear
            3'd3:    cmd = 8'b0000_0110;  // entry mode
            3'd4:    cmd = 8'b0000_1100;  // display on
            default: cmd = 8'h00;
        endcase
        return cmd;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/char_lcd_nibble_interface_unit.sv
`default_nettype none
// Channel   Handshake              Payload
// s_        s_valid / s_ready      action, byte_value, column, row, caller_is_owner
// m_        m_valid / m_ready      pin_rs, pin_enable, pin_nibble, pin_backlight,
//                                  busy_res, status
// cfg_      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per clock while the m_ side is not stalled. An item sits in the input
// register until it advances, when the sequencer state and the result register
// update together and m_valid rises. Reset (aresetn low, synchronous) clears both
// stages, the sequencer and the config registers to their defaults. A stalled m_
// side holds the result; the input register still takes one more item. cfg_ready is
// always high.
module char_lcd_nibble_interface_unit
    import chlcd_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output wire logic                   s_ready,
    input  wire logic [2:0]             s_action,
    input  wire logic [7:0]             s_byte_value,
    input  wire logic [7:0]             s_column,
    input  wire logic [7:0]             s_row,
    input  wire logic                   s_caller_is_owner,
    output wire logic                   m_valid,
    input  wire logic                   m_ready,
    output wire logic                   m_pin_rs,
    output wire logic                   m_pin_enable,
    output wire logic [3:0]             m_pin_nibble,
    output wire logic                   m_pin_backlight,
    output wire logic                   m_busy_res,
    output wire logic [1:0]             m_status,
    input  wire logic                   cfg_valid,
    output wire logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic        in_valid_reg;
    lcd_item_t   in_item_reg;
    logic        out_valid_reg;
    lcd_result_t out_res_reg;
    lcd_result_t seq_res;
    lcd_cfg_t    cfg;
    logic        out_free;
    logic        advance;

    assign out_free  = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    chlcd_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    chlcd_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (seq_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.action          <= s_action;
            in_item_reg.byte_value      <= s_byte_value;
            in_item_reg.column          <= s_column;
            in_item_reg.row             <= s_row;
            in_item_reg.caller_is_owner <= s_caller_is_owner;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= seq_res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_pin_rs        = out_res_reg.pin_rs;
    assign m_pin_enable    = out_res_reg.pin_enable;
    assign m_pin_nibble    = out_res_reg.pin_nibble;
    assign m_pin_backlight = out_res_reg.pin_backlight;
    assign m_busy_res      = out_res_reg.busy_res;
    assign m_status        = out_res_reg.status;

endmodule
`default_nettype wire

FILE: hw/rtl/chlcd_cfg_regs.sv
`default_nettype none
module chlcd_cfg_regs
    import chlcd_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   wr_en,
    input  wire logic [CFG_INDEX_W-1:0] wr_index,
    input  wire logic [CFG_DATA_W-1:0]  wr_data,
    output lcd_cfg_t                    cfg
);

    lcd_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.power_on_wait_ticks <= 16'd20000;
            cfg_reg.command_wait_ticks  <= 16'd1000;
            cfg_reg.data_wait_ticks     <= 16'd50;
            cfg_reg.enable_pulse_ticks  <= 8'd1;
        end else if (wr_en) begin
            case (wr_index)
                REG_POWER_ON_WAIT: cfg_reg.power_on_wait_ticks <= wr_data;
                REG_COMMAND_WAIT:  cfg_reg.command_wait_ticks  <= wr_data;
                REG_DATA_WAIT:     cfg_reg.data_wait_ticks     <= wr_data;
                REG_ENABLE_PULSE:  cfg_reg.enable_pulse_ticks  <= wr_data[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/chlcd_seq.sv
`default_nettype none
module chlcd_seq
    import chlcd_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  step_en,
    input  wire lcd_item_t item,
    input  wire lcd_cfg_t  cfg,
    output lcd_result_t result
);

    seq_step_t   seq_reg, seq_next;
    logic [15:0] wait_reg, wait_next;
    logic [7:0]  pulse_reg, pulse_next;
    logic [2:0]  idx_reg, idx_next;
    logic [7:0]  pend_reg, pend_next;
    logic        rs_reg, rs_next;
    logic        en_reg, en_next;
    logic [3:0]  nib_reg, nib_next;
    logic        bl_reg, bl_next;
    status_t     status;

    logic [15:0] wait_dec;
    logic [7:0]  pulse_dec;
    logic        busy;
    logic        cursor_off;
    logic [7:0]  cursor_addr;
    logic [7:0]  first_cmd;
    logic [7:0]  boot_cmd;

    assign busy      = (seq_reg != ST_IDLE);
    assign wait_dec  = (wait_reg != 16'd0) ? wait_reg - 16'd1 : 16'd0;
    assign pulse_dec = (pulse_reg != 8'd0) ? pulse_reg - 8'd1 : 8'd0;
    assign cursor_off = (item.column > 8'(NUM_COLUMNS)) || (item.row > 8'(NUM_ROWS));
    // row times 0x40 wraps to the low two row bits
    assign cursor_addr = CURSOR_BASE + {item.row[1:0], 6'd0} - ROW_STRIDE
                         + item.column - 8'd1;
    assign first_cmd = init_cmd(3'd0);
    assign boot_cmd  = init_cmd(idx_reg);

    // next state
    always_comb begin
        seq_next   = seq_reg;
        wait_next  = wait_reg;
        pulse_next = pulse_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        rs_next    = rs_reg;
        en_next    = en_reg;
        nib_next   = nib_reg;
        bl_next    = bl_reg;
        status     = STAT_OK;
        case (item.action)
            ACT_TICK: begin
                case (seq_reg)
                    ST_IDLE: ;
                    ST_BYTE_SETUP_HI, ST_BYTE_SETUP_LO: begin
                        en_next    = 1'b1;
                        pulse_next = cfg.enable_pulse_ticks;
                        seq_next   = (seq_reg == ST_BYTE_SETUP_HI) ? ST_BYTE_PULSE_HI
                                                                    : ST_BYTE_PULSE_LO;
                    end
                    ST_INIT_PULSE1, ST_INIT_PULSE2, ST_INIT_PULSE3, ST_INIT_PULSE4,
                    ST_BYTE_PULSE_HI, ST_BYTE_PULSE_LO: begin
                        pulse_next = pulse_dec;
                        if (pulse_dec == 8'd0) begin
                            en_next = 1'b0;
                            case (seq_reg)
                                ST_INIT_PULSE1: begin
                                    wait_next = INIT_WAIT_LONG;
                                    seq_next  = ST_INIT_WAIT1;
                                end
                                ST_INIT_PULSE2: begin
                                    wait_next = INIT_WAIT_SHORT;
                                    seq_next  = ST_INIT_WAIT2;
                                end
                                ST_INIT_PULSE3: begin
                                    nib_next  = INIT_NIBBLE_4BIT;
                                    wait_next = INIT_WAIT_LONG;
                                    seq_next  = ST_INIT_WAIT3;
                                end
                                ST_INIT_PULSE4: begin
                                    wait_next = INIT_WAIT_LONG;
                                    seq_next  = ST_INIT_WAIT4;
                                end
                                ST_BYTE_PULSE_HI: begin
                                    nib_next = pend_reg[3:0];
                                    seq_next = ST_BYTE_SETUP_LO;
                                end
                                default: begin
                                    wait_next = rs_reg ? cfg.data_wait_ticks
                                                       : cfg.command_wait_ticks;
                                    seq_next  = ST_BYTE_WAIT;
                                end
                            endcase
                        end
                    end
                    ST_INIT_POWER, ST_INIT_WAIT1, ST_INIT_WAIT2, ST_INIT_WAIT3: begin
                        wait_next = wait_dec;
                        if (wait_dec == 16'd0) begin
                            en_next    = 1'b1;
                            pulse_next = cfg.enable_pulse_ticks;
                            seq_next   = seq_step_t'(seq_reg + 5'd1);
                        end
                    end
                    ST_INIT_WAIT4: begin
                        wait_next = wait_dec;
                        if (wait_dec == 16'd0) begin
                            idx_next  = 3'd1;
                            pend_next = first_cmd;
                            rs_next   = 1'b0;
                            nib_next  = first_cmd[7:4];
                            en_next   = 1'b0;
                            seq_next  = ST_BYTE_SETUP_HI;
                        end
                    end
                    ST_BYTE_WAIT: begin
                        wait_next = wait_dec;
                        if (wait_dec == 16'd0) begin
                            if (idx_reg >= 3'd1 && idx_reg < 3'(INIT_CMD_COUNT)) begin
                                idx_next  = (idx_reg == 3'(INIT_CMD_COUNT - 1)) ? 3'd0
                                                                               : idx_reg + 3'd1;
                                pend_next = boot_cmd;
                                rs_next   = 1'b0;
                                nib_next  = boot_cmd[7:4];
                                en_next   = 1'b0;
                                seq_next  = ST_BYTE_SETUP_HI;
                            end else begin
                                idx_next = 3'd0;
                                seq_next = ST_IDLE;
                            end
                        end
                    end
                    default: seq_next = ST_IDLE;
                endcase
            end
            ACT_INIT: begin
                if (busy) begin
                    status = STAT_BUSY;
                end else begin
                    rs_next   = 1'b0;
                    en_next   = 1'b0;
                    nib_next  = INIT_NIBBLE_8BIT;
                    idx_next  = 3'd0;
                    wait_next = cfg.power_on_wait_ticks;
                    seq_next  = ST_INIT_POWER;
                end
            end
            ACT_COMMAND, ACT_WRITE_CHAR, ACT_BACKLIGHT_ON, ACT_BACKLIGHT_OFF,
            ACT_MOVE_CURSOR: begin
                if (!item.caller_is_owner) begin
                    status = STAT_NOT_OWNER;
                end else if (item.action == ACT_BACKLIGHT_ON) begin
                    bl_next = 1'b1;
                end else if (item.action == ACT_BACKLIGHT_OFF) begin
                    bl_next = 1'b0;
                end else if (item.action == ACT_MOVE_CURSOR && cursor_off) begin
                    status = STAT_OK;
                end else if (busy) begin
                    status = STAT_BUSY;
                end else begin
                    pend_next = (item.action == ACT_MOVE_CURSOR) ? cursor_addr
                                                                  : item.byte_value;
                    nib_next  = (item.action == ACT_MOVE_CURSOR) ? cursor_addr[7:4]
                                                                  : item.byte_value[7:4];
                    rs_next   = (item.action == ACT_WRITE_CHAR);
                    en_next   = 1'b0;
                    seq_next  = ST_BYTE_SETUP_HI;
                end
            end
            default: ;
        endcase
    end

    // outputs: pin levels after the item
    always_comb begin
        result.pin_rs        = rs_next;
        result.pin_enable    = en_next;
        result.pin_nibble    = nib_next;
        result.pin_backlight = bl_next;
        result.busy_res      = (seq_next != ST_IDLE);
        result.status        = status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg   <= ST_IDLE;
            wait_reg  <= 16'd0;
            pulse_reg <= 8'd0;
            idx_reg   <= 3'd0;
            pend_reg  <= 8'd0;
            rs_reg    <= 1'b0;
            en_reg    <= 1'b0;
            nib_reg   <= 4'd0;
            bl_reg    <= 1'b0;
        end else if (step_en) begin
            seq_reg   <= seq_next;
            wait_reg  <= wait_next;
            pulse_reg <= pulse_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            rs_reg    <= rs_next;
            en_reg    <= en_next;
            nib_reg   <= nib_next;
            bl_reg    <= bl_next;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/chlcd_checker.sv
`default_nettype none
module chlcd_checker
    import chlcd_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_pin_rs,
    input wire logic       m_pin_enable,
    input wire logic [3:0] m_pin_nibble,
    input wire logic       m_busy_res,
    input wire logic [1:0] m_status
);

    // a stalled item keeps its nibble and RS pins
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pin_nibble) && $stable(m_pin_rs))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != 2'd3)
        else $error("undefined status code");

    // the strobe is only raised inside a running sequence
    a_enable_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pin_enable |-> m_busy_res)
        else $error("enable high while idle");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind char_lcd_nibble_interface_unit chlcd_checker u_chlcd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_pin_rs     (m_pin_rs),
    .m_pin_enable (m_pin_enable),
    .m_pin_nibble (m_pin_nibble),
    .m_busy_res   (m_busy_res),
    .m_status     (m_status)
);
`default_nettype wire
